// ===== rtl/su4om_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package su4om_pkg;

  localparam int LABEL_BITS_DEF = 8;
  localparam int MULT_BITS      = 24;
  localparam logic [MULT_BITS-1:0] MULT_MAX = {MULT_BITS{1'b1}};

  // Extra bits over the label width that keep every signed intermediate exact.
  localparam int WORK_EXTRA = 6;

  typedef struct packed {
    logic busy;
    logic valid;
  } pe_status_t;

endpackage

`default_nettype wire

// ===== rtl/su4om_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface su4om_item_if #(
  parameter int LABEL_BITS = su4om_pkg::LABEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [LABEL_BITS-1:0] factor_a_row1;
  logic [LABEL_BITS-1:0] factor_a_row2;
  logic [LABEL_BITS-1:0] factor_a_row3;
  logic [LABEL_BITS-1:0] factor_a_row4;
  logic [LABEL_BITS-1:0] factor_b_row1;
  logic [LABEL_BITS-1:0] factor_b_row2;
  logic [LABEL_BITS-1:0] factor_b_row3;
  logic [LABEL_BITS-1:0] factor_b_row4;
  logic [LABEL_BITS-1:0] target_row1;
  logic [LABEL_BITS-1:0] target_row2;
  logic [LABEL_BITS-1:0] target_row3;
  logic [LABEL_BITS-1:0] target_row4;

  modport source (
    output valid, factor_a_row1, factor_a_row2, factor_a_row3, factor_a_row4,
           factor_b_row1, factor_b_row2, factor_b_row3, factor_b_row4,
           target_row1, target_row2, target_row3, target_row4,
    input  ready
  );
  modport sink (
    input  valid, factor_a_row1, factor_a_row2, factor_a_row3, factor_a_row4,
           factor_b_row1, factor_b_row2, factor_b_row3, factor_b_row4,
           target_row1, target_row2, target_row3, target_row4,
    output ready
  );
endinterface

interface su4om_result_if ();
  logic                             valid;
  logic                             ready;
  logic [su4om_pkg::MULT_BITS-1:0]  multiplicity;
  logic                             box_mismatch;

  modport source (output valid, multiplicity, box_mismatch, input ready);
  modport sink (input valid, multiplicity, box_mismatch, output ready);
endinterface

`default_nettype wire

// ===== rtl/su4om_pair_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module su4om_pair_eval #(
  parameter int W = su4om_pkg::LABEL_BITS_DEF + su4om_pkg::WORK_EXTRA
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 issue,
  input  wire logic signed [W-1:0]  e1,
  input  wire logic signed [W-1:0]  e2,
  input  wire logic signed [W-1:0]  c0,
  input  wire logic signed [W-1:0]  c1,
  input  wire logic signed [W-1:0]  c2,
  input  wire logic signed [W-1:0]  c3,
  input  wire logic signed [W-1:0]  c4,
  input  wire logic signed [W-1:0]  u2,
  input  wire logic signed [W-1:0]  d1,
  input  wire logic signed [W-1:0]  d2,
  input  wire logic signed [W-1:0]  d3,
  output su4om_pkg::pe_status_t     status,
  output logic signed [W-1:0]       lo,
  output logic signed [W-1:0]       hi
);

  typedef logic signed [W-1:0] sval_t;

  function automatic sval_t smax(input sval_t a, input sval_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic sval_t smin(input sval_t a, input sval_t b);
    return (a < b) ? a : b;
  endfunction

  logic  p1;
  logic  p2;
  sval_t t0, t1, t2, t3, t4;
  sval_t h0, h1, h3, h4;
  sval_t t3_adj;
  sval_t t6;
  sval_t lo_next;
  sval_t hi_next;

  // The half term truncates toward zero, so negative values are biased by one.
  always_comb begin
    t3_adj  = t3 + $signed({{(W-1){1'b0}}, t3[W-1]});
    t6      = t3_adj >>> 1;
    lo_next = smax(smax(smax(t0, t1), smax(t2, t3)), smax(smax(t4, '0), t6));
    hi_next = smin(smin(smin(h0, h1), smin(d2, h3)), h4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1;
    end
    t0 <= c0 + sval_t'({e2[W-2:0], 1'b0}) - e1;
    t1 <= c1 + e2 - e1;
    t2 <= c2 + e2;
    t3 <= c3 + e2;
    t4 <= c4 + e1;
    h0 <= u2 - e1;
    h1 <= d1 + e2;
    h3 <= d3 + e2 - e1;
    h4 <= u2 - e2;
    lo <= lo_next;
    hi <= hi_next;
  end

  assign status.busy  = p1 | p2;
  assign status.valid = p2;

endmodule

`default_nettype wire

// ===== rtl/su4_outer_multiplicity.sv =====
`timescale 1ns / 1ps
`default_nettype none

// SU(4) outer-product multiplicity counter.
// The operand channel carries three four-row labels: factor A, factor B and
// the candidate target. The result channel returns the multiplicity and a
// flag that is set when the box surplus is negative or not a multiple of four.
// One transaction is processed at a time; operand.ready is high only while the
// block is idle. After acceptance, setup forms the row sums, checks the box,
// pads the target and computes the bound constants; a box mismatch goes
// straight to the result. Otherwise the sequencer visits each eta1 row in turn
// and issues each (eta1, eta2) pair to a two-stage bound evaluator, whose
// results are summed into the accumulator; it waits for the evaluator to drain
// before the result becomes valid. The result is held in the output register
// until result.ready is seen; a stalled receiver simply holds the block in that
// state. A synchronous reset returns the block to idle with no result pending.

module su4_outer_multiplicity #(
  parameter int LABEL_BITS = su4om_pkg::LABEL_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  su4om_item_if.sink      operand,
  su4om_result_if.source  result
);

  localparam int W    = LABEL_BITS + su4om_pkg::WORK_EXTRA;
  localparam int MB   = su4om_pkg::MULT_BITS;
  localparam int SUMW = ((W > MB) ? W : MB) + 1;

  typedef logic signed [W-1:0] sval_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_BOX, S_PAD, S_CONST, S_ROW, S_PAIR, S_OUT
  } state_t;

  function automatic sval_t ext(input logic [LABEL_BITS-1:0] x);
    return sval_t'({{(W-LABEL_BITS){1'b0}}, x});
  endfunction

  function automatic sval_t smax(input sval_t a, input sval_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic sval_t smin(input sval_t a, input sval_t b);
    return (a < b) ? a : b;
  endfunction

  state_t state;
  logic   drain;
  logic   box;
  logic [MB-1:0] mult;

  sval_t l1, l2, l3, u1, u2, u3, v1, v2, v3;
  sval_t suml, sumu, sumv, sumvp, v4;
  sval_t c0, c1, c2, c3, c4, d1, d2, d3;
  sval_t e2off, e2cap;
  sval_t e1, e1hi, e2, e2hi;

  sval_t n4;
  sval_t e2lo_c;
  sval_t e2hi_c;
  logic  issue;
  sval_t lo, hi;
  sval_t span;
  logic [SUMW-1:0] acc_sum;
  su4om_pkg::pe_status_t pe_status;

  always_comb begin
    n4     = suml + sumu - sumv;
    e2lo_c = smax(e1 + e2off, '0);
    e2hi_c = smin(smin(e1, u3), e2cap);
    issue  = (state == S_PAIR);
    span   = hi - lo + sval_t'(1);
    acc_sum = {{(SUMW-MB){1'b0}}, mult} + {{(SUMW-W){1'b0}}, span};
  end

  su4om_pair_eval #(.W(W)) u_eval (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .e1     (e1),
    .e2     (e2),
    .c0     (c0),
    .c1     (c1),
    .c2     (c2),
    .c3     (c3),
    .c4     (c4),
    .u2     (u2),
    .d1     (d1),
    .d2     (d2),
    .d3     (d3),
    .status (pe_status),
    .lo     (lo),
    .hi     (hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= 1'b0;
    end else begin
      if (pe_status.valid && (hi >= lo)) begin
        if (acc_sum > {{(SUMW-MB){1'b0}}, su4om_pkg::MULT_MAX}) begin
          mult <= su4om_pkg::MULT_MAX;
        end else begin
          mult <= acc_sum[MB-1:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (operand.valid) begin
            l1 <= ext(operand.factor_a_row1) - ext(operand.factor_a_row4);
            l2 <= ext(operand.factor_a_row2) - ext(operand.factor_a_row4);
            l3 <= ext(operand.factor_a_row3) - ext(operand.factor_a_row4);
            u1 <= ext(operand.factor_b_row1) - ext(operand.factor_b_row4);
            u2 <= ext(operand.factor_b_row2) - ext(operand.factor_b_row4);
            u3 <= ext(operand.factor_b_row3) - ext(operand.factor_b_row4);
            v1 <= ext(operand.target_row1) - ext(operand.target_row4);
            v2 <= ext(operand.target_row2) - ext(operand.target_row4);
            v3 <= ext(operand.target_row3) - ext(operand.target_row4);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          suml  <= l1 + l2 + l3;
          sumu  <= u1 + u2 + u3;
          sumv  <= v1 + v2 + v3;
          state <= S_BOX;
        end
        S_BOX: begin
          v4 <= n4 >>> 2;
          if (n4[W-1] || (n4[1:0] != 2'b00)) begin
            box   <= 1'b1;
            mult  <= '0;
            state <= S_OUT;
          end else begin
            box   <= 1'b0;
            state <= S_PAD;
          end
        end
        S_PAD: begin
          v1    <= v1 + v4;
          v2    <= v2 + v4;
          v3    <= v3 + v4;
          sumvp <= sumv + v4 + sval_t'({v4[W-2:0], 1'b0});
          state <= S_CONST;
        end
        S_CONST: begin
          c0    <= u2 + v4 - v3 - u3;
          c1    <= l3 + u2 - v3;
          c2    <= v4 - l3 - u3;
          c3    <= suml + sval_t'({u2[W-2:0], 1'b0}) - sumvp;
          c4    <= l1 + l2 + u2 - v1 - v2;
          d1    <= v4 - u3;
          d2    <= u2 - u3;
          d3    <= l2 - v3 + u2;
          e2off <= v3 - v2;
          e2cap <= v3 - v4;
          e1    <= smax('0, v2 - l1);
          e1hi  <= smin(v2 - l2, v1 - l1);
          mult  <= '0;
          drain <= 1'b0;
          state <= S_ROW;
        end
        S_ROW: begin
          if (drain || (e1 > e1hi)) begin
            drain <= 1'b1;
            if (!pe_status.busy && drain) begin
              state <= S_OUT;
            end
          end else if (e2lo_c <= e2hi_c) begin
            e2    <= e2lo_c;
            e2hi  <= e2hi_c;
            state <= S_PAIR;
          end else begin
            e1 <= e1 + sval_t'(1);
          end
        end
        S_PAIR: begin
          if (e2 == e2hi) begin
            e1    <= e1 + sval_t'(1);
            state <= S_ROW;
          end else begin
            e2 <= e2 + sval_t'(1);
          end
        end
        S_OUT: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign operand.ready       = (state == S_IDLE);
  assign result.valid        = (state == S_OUT);
  assign result.multiplicity = mult;
  assign result.box_mismatch = box;

endmodule

`default_nettype wire

// ===== tb/su4om_checker.sv =====
`timescale 1ns / 1ps

module su4om_checker (
  input  wire logic clk,
  input  wire logic rst,
  su4om_item_if     operand,
  su4om_result_if   result,
  input  wire logic finish_check,
  output int        pending,
  output int        fail_count
);

  localparam longint COUNT_CEIL = (longint'(1) << su4om_pkg::MULT_BITS) - 1;

  typedef struct {
    logic [su4om_pkg::MULT_BITS-1:0] multiplicity;
    logic                            box_mismatch;
  } mult_result_t;

  mult_result_t expected_q [$];
  bit           leftover_checked = 1'b0;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic longint lmax(longint p, longint q);
    return (p > q) ? p : q;
  endfunction

  function automatic longint lmin(longint p, longint q);
    return (p < q) ? p : q;
  endfunction

  function automatic mult_result_t count_multiplicity(input longint fa [4],
                                                      input longint fb [4],
                                                      input longint tg [4]);
    longint l1, l2, l3, u1, u2, u3, w1, w2, w3;
    longint n4, v4, e1, e2, e2lo, e2hi, half, lo, hi, total;
    mult_result_t r;
    l1 = fa[0] - fa[3];
    l2 = fa[1] - fa[3];
    l3 = fa[2] - fa[3];
    u1 = fb[0] - fb[3];
    u2 = fb[1] - fb[3];
    u3 = fb[2] - fb[3];
    w1 = tg[0] - tg[3];
    w2 = tg[1] - tg[3];
    w3 = tg[2] - tg[3];
    n4 = l1 + l2 + l3 + u1 + u2 + u3 - (w1 + w2 + w3);
    r.multiplicity = '0;
    r.box_mismatch = 1'b0;
    if (n4 < 0 || (n4 % 4) != 0) begin
      r.box_mismatch = 1'b1;
      return r;
    end
    v4 = n4 / 4;
    w1 += v4;
    w2 += v4;
    w3 += v4;
    total = 0;
    for (e1 = lmax(0, w2 - l1); e1 <= lmin(w2 - l2, w1 - l1); e1++) begin
      e2lo = lmax(w3 - w2 + e1, 0);
      e2hi = lmin(lmin(e1, u3), w3 - v4);
      for (e2 = e2lo; e2 <= e2hi; e2++) begin
        half = e2 + l1 + l2 + l3 + 2 * u2 - w1 - w2 - w3;
        lo = lmax(2 * e2 - e1 + u2 + v4 - w3 - u3, e2 - e1 + l3 + u2 - w3);
        lo = lmax(lo, e2 + v4 - l3 - u3);
        lo = lmax(lo, half);
        lo = lmax(lo, e1 + l1 + l2 + u2 - w1 - w2);
        lo = lmax(lo, 0);
        lo = lmax(lo, half / 2);
        hi = lmin(u2 - e1, v4 - u3 + e2);
        hi = lmin(hi, u2 - u3);
        hi = lmin(hi, l2 - w3 + u2 - e1 + e2);
        hi = lmin(hi, u2 - e2);
        if (hi >= lo) begin
          total += hi - lo + 1;
          if (total > COUNT_CEIL) begin
            total = COUNT_CEIL;
          end
        end
      end
    end
    r.multiplicity = total[su4om_pkg::MULT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    longint       fa [4];
    longint       fb [4];
    longint       tg [4];
    mult_result_t want;
    if (rst) begin
      expected_q.delete();
    end else begin
      if (operand.valid && operand.ready) begin
        fa[0] = longint'(operand.factor_a_row1);
        fa[1] = longint'(operand.factor_a_row2);
        fa[2] = longint'(operand.factor_a_row3);
        fa[3] = longint'(operand.factor_a_row4);
        fb[0] = longint'(operand.factor_b_row1);
        fb[1] = longint'(operand.factor_b_row2);
        fb[2] = longint'(operand.factor_b_row3);
        fb[3] = longint'(operand.factor_b_row4);
        tg[0] = longint'(operand.target_row1);
        tg[1] = longint'(operand.target_row2);
        tg[2] = longint'(operand.target_row3);
        tg[3] = longint'(operand.target_row4);
        expected_q.push_back(count_multiplicity(fa, fb, tg));
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: multiplicity %0d, box_mismatch %0b",
                 result.multiplicity, result.box_mismatch);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (result.multiplicity !== want.multiplicity) begin
            $error("multiplicity: expected %0d, actual %0d",
                   want.multiplicity, result.multiplicity);
            fail_count++;
          end
          if (result.box_mismatch !== want.box_mismatch) begin
            $error("box_mismatch: expected %0b, actual %0b",
                   want.box_mismatch, result.box_mismatch);
            fail_count++;
          end
        end
      end
      if (finish_check && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_q.size() != 0) begin
          $error("%0d expected result transactions never arrived", expected_q.size());
          fail_count += expected_q.size();
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/tb_su4_outer_multiplicity.sv =====
`timescale 1ns / 1ps

module tb_su4_outer_multiplicity;

  localparam int LB     = su4om_pkg::LABEL_BITS_DEF;
  localparam int ROW_MAX = (1 << LB) - 1;

  typedef logic [3:0][LB-1:0] label_t;

  typedef struct packed {
    label_t fa;
    label_t fb;
    label_t tg;
  } labels_t;

  logic clk;
  logic rst;
  logic finish_check;
  int   pending;
  int   fail_count;
  int   items_sent = 0;
  bit   send_quiet = 1'b0;
  bit   sink_quiet = 1'b0;

  su4om_item_if #(.LABEL_BITS(LB)) op_if ();
  su4om_result_if                  res_if ();

  su4_outer_multiplicity #(.LABEL_BITS(LB)) DUT (
    .clk     (clk),
    .rst     (rst),
    .operand (op_if.sink),
    .result  (res_if.source)
  );

  su4om_checker CHK (
    .clk          (clk),
    .rst          (rst),
    .operand      (op_if),
    .result       (res_if),
    .finish_check (finish_check),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #(40_000_000);
    $display("tb_su4_outer_multiplicity: FAIL");
    $finish;
  end

  function automatic int pick_idle(bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic label_t order_rows(label_t l);
    logic [LB-1:0] tmp;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3 - i; j++) begin
        if (l[j] < l[j+1]) begin
          tmp    = l[j];
          l[j]   = l[j+1];
          l[j+1] = tmp;
        end
      end
    end
    return l;
  endfunction

  function automatic int label_weight(label_t l);
    int s, r4;
    s  = int'(l[0]);
    s += int'(l[1]);
    s += int'(l[2]);
    r4 = int'(l[3]);
    return s - 3 * r4;
  endfunction

  function automatic int box_surplus(labels_t x);
    return label_weight(x.fa) + label_weight(x.fb) - label_weight(x.tg);
  endfunction

  function automatic bit surplus_ok(labels_t x);
    int n4;
    n4 = box_surplus(x);
    return (n4 >= 0) && (n4 % 4 == 0);
  endfunction

  function automatic labels_t labels_of(int a1, int a2, int a3, int a4,
                                        int b1, int b2, int b3, int b4,
                                        int t1, int t2, int t3, int t4);
    labels_t x;
    x.fa = {a4[LB-1:0], a3[LB-1:0], a2[LB-1:0], a1[LB-1:0]};
    x.fb = {b4[LB-1:0], b3[LB-1:0], b2[LB-1:0], b1[LB-1:0]};
    x.tg = {t4[LB-1:0], t3[LB-1:0], t2[LB-1:0], t1[LB-1:0]};
    return x;
  endfunction

  // Target built by spreading the boxes of B over the rows of A, so that it
  // lies near the product and the counting loops do real work.
  function automatic labels_t product_component(int maxv);
    labels_t x;
    int added [4];
    int boxes, r, cut, cap;
    for (int i = 0; i < 4; i++) begin
      x.fa[i]  = LB'($urandom_range(0, maxv));
      x.fb[i]  = LB'($urandom_range(0, maxv));
      added[i] = 0;
    end
    x.fa = order_rows(x.fa);
    x.fb = order_rows(x.fb);
    if ($urandom_range(0, 3) != 0) begin
      x.fb[3] = '0;
    end
    boxes = int'(x.fb[0]) + int'(x.fb[1]) + int'(x.fb[2]) + int'(x.fb[3]);
    cap   = int'(x.fb[0]);
    for (int k = 0; k < boxes; k++) begin
      r = $urandom_range(0, 3);
      while (added[r] >= cap) begin
        r = (r + 1) % 4;
      end
      added[r]++;
    end
    for (int i = 0; i < 4; i++) begin
      x.tg[i] = LB'(int'(x.fa[i]) + added[i]);
    end
    x.tg = order_rows(x.tg);
    cut = $urandom_range(0, 1) ? $urandom_range(0, x.tg[3]) : 0;
    for (int i = 0; i < 4; i++) begin
      x.tg[i] = LB'(int'(x.tg[i]) - cut);
    end
    return x;
  endfunction

  function automatic labels_t loose_item(int maxv);
    labels_t x;
    do begin
      for (int i = 0; i < 4; i++) begin
        x.fa[i] = LB'($urandom_range(0, maxv));
        x.fb[i] = LB'($urandom_range(0, maxv));
        x.tg[i] = LB'($urandom_range(0, maxv));
      end
      if ($urandom_range(0, 1)) begin
        x.fa = order_rows(x.fa);
        x.fb = order_rows(x.fb);
        x.tg = order_rows(x.tg);
      end
    end while (!surplus_ok(x));
    return x;
  endfunction

  function automatic labels_t broken_item();
    labels_t x;
    do begin
      for (int i = 0; i < 4; i++) begin
        x.fa[i] = LB'($urandom_range(0, ROW_MAX));
        x.fb[i] = LB'($urandom_range(0, ROW_MAX));
        x.tg[i] = LB'($urandom_range(0, ROW_MAX));
      end
    end while (surplus_ok(x));
    return x;
  endfunction

  task automatic offer(input labels_t x);
    int idle;
    idle = pick_idle(send_quiet);
    if (idle > 0) begin
      op_if.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    op_if.factor_a_row1 <= x.fa[0];
    op_if.factor_a_row2 <= x.fa[1];
    op_if.factor_a_row3 <= x.fa[2];
    op_if.factor_a_row4 <= x.fa[3];
    op_if.factor_b_row1 <= x.fb[0];
    op_if.factor_b_row2 <= x.fb[1];
    op_if.factor_b_row3 <= x.fb[2];
    op_if.factor_b_row4 <= x.fb[3];
    op_if.target_row1   <= x.tg[0];
    op_if.target_row2   <= x.tg[1];
    op_if.target_row3   <= x.tg[2];
    op_if.target_row4   <= x.tg[3];
    op_if.valid         <= 1'b1;
    @(posedge clk);
    while (!op_if.ready) begin
      @(posedge clk);
    end
    items_sent++;
    if ($urandom_range(0, 99) < 3) begin
      send_quiet = !send_quiet;
    end
    @(negedge clk);
  endtask

  initial begin : result_sink
    int hold_left, long_holds;
    hold_left  = 0;
    long_holds = 0;
    res_if.ready = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_holds < 2 && items_sent >= ((long_holds == 0) ? 80 : 380)) begin
        long_holds++;
        res_if.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= 1'b1;
        hold_left = pick_idle(sink_quiet);
        if ($urandom_range(0, 99) < 3) begin
          sink_quiet = !sink_quiet;
        end
      end
    end
  end

  initial begin : operand_source
    int pick, large_left;
    large_left          = 5;
    rst                 = 1'b1;
    finish_check        = 1'b0;
    op_if.valid         = 1'b0;
    op_if.factor_a_row1 = '0;
    op_if.factor_a_row2 = '0;
    op_if.factor_a_row3 = '0;
    op_if.factor_a_row4 = '0;
    op_if.factor_b_row1 = '0;
    op_if.factor_b_row2 = '0;
    op_if.factor_b_row3 = '0;
    op_if.factor_b_row4 = '0;
    op_if.target_row1   = '0;
    op_if.target_row2   = '0;
    op_if.target_row3   = '0;
    op_if.target_row4   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer(labels_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer(labels_of(255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255));
    offer(labels_of(3, 1, 0, 0, 2, 1, 0, 0, 5, 2, 0, 0));
    offer(labels_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    offer(labels_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer(labels_of(4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer(labels_of(0, 2, 5, 1, 3, 0, 4, 0, 1, 3, 3, 0));
    offer(labels_of(2, 1, 1, 0, 1, 1, 0, 0, 2, 2, 1, 1));
    offer(labels_of(170, 85, 170, 85, 85, 170, 85, 170, 170, 170, 85, 85));
    offer(labels_of(127, 85, 42, 0, 127, 85, 42, 0, 212, 170, 126, 0));
    offer(labels_of(255, 170, 85, 0, 255, 170, 85, 0, 255, 255, 254, 0));
    offer(labels_of(6, 4, 2, 0, 3, 2, 1, 0, 0, 0, 0, 255));
    for (int k = 0; k < 6; k++) begin
      offer(product_component(6));
    end

    for (int n = 0; n < 570; n++) begin
      if (n == 150 || n == 420) begin
        op_if.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2 && large_left > 0) begin
        large_left--;
        offer(product_component(127));
      end else if (pick < 8) begin
        offer(product_component(30));
      end else if (pick < 60) begin
        offer(product_component(8));
      end else if (pick < 75) begin
        offer(loose_item(8));
      end else begin
        offer(broken_item());
      end
    end

    op_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
    finish_check <= 1'b1;
    repeat (3) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_su4_outer_multiplicity: PASS");
    end else begin
      $display("tb_su4_outer_multiplicity: FAIL");
    end
    $finish;
  end

endmodule
